// ===== rtl/lpsm_pkg.sv =====
// Shared constants, codes and helpers for the LIKE pattern string matcher.
package lpsm_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int MAX_ENTRIES_DEF = 65536;

    localparam int PAT_BYTES   = 32;
    localparam int PAT_BITS    = PAT_BYTES * 8;
    localparam int WORD_W      = 64;
    localparam int BYTE_IDX_W  = 7;
    localparam int LEN_W       = 6;
    localparam int PRE_W       = 5;
    localparam int MODE_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int INDEX_W     = 16;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;

    typedef enum logic [MODE_W-1:0] {
        MODE_CONTAINS = 3'd0,
        MODE_PREFIX   = 3'd1,
        MODE_SUFFIX   = 3'd2,
        MODE_EXACT    = 3'd3,
        MODE_AFFIX    = 3'd4
    } match_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MATCH_MODE     = 3'd0,
        REG_PATTERN_LENGTH = 3'd1,
        REG_PREFIX_LENGTH  = 3'd2,
        REG_PATTERN_WORD0  = 3'd3,
        REG_PATTERN_WORD1  = 3'd4,
        REG_PATTERN_WORD2  = 3'd5,
        REG_PATTERN_WORD3  = 3'd6
    } cfg_reg_t;

    // Per-item control handed to the cell row.
    typedef struct packed {
        logic step;
        logic clear;
    } row_ctrl_t;

    function automatic logic [7:0] pat_byte(input logic [PAT_BITS-1:0] pat,
                                            input logic [BYTE_IDX_W-1:0] idx);
        logic [7:0] b;
        b = pat[{idx[4:0], 3'b000} +: 8];
        if (idx[BYTE_IDX_W-1:5] != '0) begin
            b = 8'h00;
        end
        return b;
    endfunction

endpackage

// ===== rtl/lpsm_cell.sv =====
// One shift-and cell: holds one partial-match bit and passes it on.
module lpsm_cell
    import lpsm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  row_ctrl_t ctrl,
    input  logic      en,
    input  logic [7:0] pat_byte_i,
    input  logic [7:0] text_byte,
    input  logic      prev_bit,
    output logic      bit_now,
    output logic      bit_q
);

    logic bit_reg;
    logic bit_next;

    always_comb begin
        bit_now = bit_reg;
        if (ctrl.step) begin
            bit_now = prev_bit & en & (pat_byte_i == text_byte);
        end
        bit_next = bit_reg;
        if (ctrl.clear) begin
            bit_next = 1'b0;
        end else if (ctrl.step) begin
            bit_next = bit_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= 1'b0;
        end else begin
            bit_reg <= bit_next;
        end
    end

    assign bit_q = bit_reg;

endmodule

// ===== rtl/lpsm_chain.sv =====
// Row of shift-and cells, one per pattern position of the matched part.
module lpsm_chain
    import lpsm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  row_ctrl_t              ctrl,
    input  logic [PAT_BITS-1:0]    pattern,
    input  logic [LEN_W-1:0]       offset,
    input  logic [LEN_W-1:0]       sub_len,
    input  logic [7:0]             text_byte,
    output logic [MAX_PATTERN-1:0] vec_now
);

    logic [MAX_PATTERN-1:0] vec_q;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic [7:0] pb;
        logic       en;
        logic       prev;

        assign pb = pat_byte(pattern, BYTE_IDX_W'(offset) + BYTE_IDX_W'(k));
        assign en = BYTE_IDX_W'(k) < BYTE_IDX_W'(sub_len);
        if (k == 0) begin : g_head
            assign prev = 1'b1;
        end else begin : g_link
            assign prev = vec_q[k-1];
        end

        lpsm_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .en         (en),
            .pat_byte_i (pb),
            .text_byte  (text_byte),
            .prev_bit   (prev),
            .bit_now    (vec_now[k]),
            .bit_q      (vec_q[k])
        );
    end

endmodule

// ===== rtl/like_pattern_string_matcher_top.sv =====
// Top level of the LIKE pattern string matcher: config, prefix check, verdict, output.
//
//  channel | direction | handshake               | payload
//  s_      | in        | s_tvalid / s_tready     | tdata text_byte, tuser has_byte, tlast end
//  m_      | out       | m_tvalid / m_tready     | tdata entry_index, is_match
//  cfg_    | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  One byte per cycle while s_tready is high: every cell updates its bit in the cycle the byte is accepted.
//  The verdict of a string is registered at its end byte and shown on the next cycle.
//  s_tready is low only while a result waits and m_tready is low.
//  Synchronous reset restores the register reset values; cfg_ready is always high.
module like_pattern_string_matcher_top
    import lpsm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] text_byte
    input  logic                  s_tuser,   // [0] has_byte
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [15:0] entry_index, [16] is_match, zero fill
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data
);

    localparam int CNT_W = $clog2(MAX_ENTRIES);
    localparam int IDX_W = $clog2(MAX_PATTERN);

    logic [MODE_W-1:0]   mode_reg;
    logic [LEN_W-1:0]    plen_reg;
    logic [PRE_W-1:0]    prelen_reg;
    logic [PAT_BITS-1:0] pattern_reg;

    logic                prefix_ok_reg, prefix_ok_next;
    logic                found_reg, found_next;
    logic [LEN_W-1:0]    seen_reg, seen_next;
    logic [CNT_W-1:0]    entry_reg;
    logic                m_valid_reg;
    logic [INDEX_W-1:0]  m_index_reg;
    logic                m_match_reg;

    logic [LEN_W-1:0]       len_eff, off, sub, plim;
    logic [MAX_PATTERN-1:0] vec_now;
    logic                   acc, has, tail_bit, tail, match;
    row_ctrl_t              ctrl;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign acc       = s_tvalid && s_tready;
    assign has       = s_tuser;
    assign ctrl.step  = acc && has;
    assign ctrl.clear = acc && s_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_CONTAINS;
            plen_reg    <= LEN_W'(1);
            prelen_reg  <= '0;
            pattern_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MATCH_MODE:     mode_reg   <= cfg_data[MODE_W-1:0];
                REG_PATTERN_LENGTH: plen_reg   <= cfg_data[LEN_W-1:0];
                REG_PREFIX_LENGTH:  prelen_reg <= cfg_data[PRE_W-1:0];
                REG_PATTERN_WORD0:  pattern_reg[0*WORD_W +: WORD_W] <= cfg_data;
                REG_PATTERN_WORD1:  pattern_reg[1*WORD_W +: WORD_W] <= cfg_data;
                REG_PATTERN_WORD2:  pattern_reg[2*WORD_W +: WORD_W] <= cfg_data;
                REG_PATTERN_WORD3:  pattern_reg[3*WORD_W +: WORD_W] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        len_eff = plen_reg;
        if ({1'b0, plen_reg} > (LEN_W+1)'(MAX_PATTERN)) begin
            len_eff = LEN_W'(MAX_PATTERN);
        end
        off = '0;
        if (mode_reg == MODE_AFFIX) begin
            off = (LEN_W'(prelen_reg) > len_eff) ? len_eff : LEN_W'(prelen_reg);
        end
        sub  = len_eff - off;
        plim = (mode_reg == MODE_AFFIX) ? off : len_eff;
    end

    lpsm_chain #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .pattern   (pattern_reg),
        .offset    (off),
        .sub_len   (sub),
        .text_byte (s_tdata[7:0]),
        .vec_now   (vec_now)
    );

    always_comb begin
        tail_bit = (sub != '0) && vec_now[IDX_W'(sub - LEN_W'(1))];
        tail     = (sub == '0) || tail_bit;

        found_next     = found_reg || (has && tail_bit);
        prefix_ok_next = prefix_ok_reg;
        seen_next      = seen_reg;
        if (has) begin
            if (seen_reg < plim &&
                pat_byte(pattern_reg, BYTE_IDX_W'(seen_reg)) != s_tdata[7:0]) begin
                prefix_ok_next = 1'b0;
            end
            if (seen_reg != '1) begin
                seen_next = seen_reg + LEN_W'(1);
            end
        end

        case (mode_reg)
            MODE_CONTAINS: match = (len_eff == '0) || found_next;
            MODE_PREFIX:   match = prefix_ok_next && (seen_next >= len_eff);
            MODE_SUFFIX:   match = tail;
            MODE_EXACT:    match = prefix_ok_next && (seen_next == len_eff);
            MODE_AFFIX:    match = prefix_ok_next && (seen_next >= len_eff) && tail;
            default:       match = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_ok_reg <= 1'b1;
            found_reg     <= 1'b0;
            seen_reg      <= '0;
            entry_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (acc) begin
                if (s_tlast) begin
                    prefix_ok_reg <= 1'b1;
                    found_reg     <= 1'b0;
                    seen_reg      <= '0;
                    entry_reg     <= (entry_reg == CNT_W'(MAX_ENTRIES - 1)) ?
                                     '0 : entry_reg + CNT_W'(1);
                end else begin
                    prefix_ok_reg <= prefix_ok_next;
                    found_reg     <= found_next;
                    seen_reg      <= seen_next;
                end
            end
            if (acc && s_tlast) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && s_tlast) begin
            m_index_reg <= INDEX_W'(entry_reg);
            m_match_reg <= match;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - INDEX_W - 1){1'b0}}, m_match_reg, m_index_reg};

    a_hold_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while a result is held");

    a_result_follows_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && s_tlast) |=> (m_valid_reg && m_index_reg == INDEX_W'($past(entry_reg))))
        else $error("string end without result");

    a_entry_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && s_tlast && entry_reg != CNT_W'(MAX_ENTRIES - 1))
        |=> entry_reg == $past(entry_reg) + CNT_W'(1))
        else $error("entry counter did not advance");

    a_string_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && s_tlast) |=> (seen_reg == '0 && prefix_ok_reg && !found_reg))
        else $error("per-string state not cleared");

endmodule
